### rtl/rank_filter_3x3_rgb_top_macros.svh
// Assertion macros for the 3x3 RGB rank filter.
// Expects clk and rst_n in the scope of use.
`ifndef RANK_FILTER_3X3_RGB_TOP_MACROS_SVH
`define RANK_FILTER_3X3_RGB_TOP_MACROS_SVH

// same-cycle implication
`define RFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rfr_pkg.sv
// Shared types and constants of the 3x3 RGB rank filter.
// No dependencies.
`default_nettype none

package rfr_pkg;

    localparam int WIN_SIZE    = 9;
    localparam int MEDIAN_RANK = 4;
    localparam int MAX_RANK    = 8;
    localparam int RANK_W      = 4;
    localparam int NUM_CH      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int XW         = 10;
    localparam int YW         = 12;
    localparam int FW_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [YW-1:0]   FRAME_HEIGHT_RST = 12'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [XW-1:0] pixel_x;
        logic [YW-1:0] pixel_y;
        logic [7:0]    red_out;
        logic [7:0]    green_out;
        logic [7:0]    blue_out;
        logic [7:0]    alpha_out;
        logic          was_filtered;
        logic          last_of_run;
    } res_t;

    // line store packing: red in the low byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [YW-1:0]   frame_height;
        logic            filter_mode;
    } cfg_t;

    typedef logic [NUM_CH-1:0][WIN_SIZE-1:0][7:0] rgb_win_t;

    typedef struct packed {
        rgb_win_t      win;
        logic [7:0]    center_alpha;
        pix_t          pix;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          do_filt;
        logic          do_border;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

`default_nettype wire

### rtl/rfr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read during write to the same address returns the old word. No dependencies.
`default_nettype none

module rfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/rfr_front.sv
// Front end: position counters, line stores, 3x3 window and classification.
// Uses rfr_pkg and rfr_ram; pushes classified windows into the queue.
`default_nettype none

module rfr_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rfr_pkg::cfg_t    cfg,
    input  wire logic             pix_valid,
    output      logic             pix_ready,
    input  wire rfr_pkg::pix_in_t pix_data,
    input  wire rfr_pkg::q_stat_t q_stat,
    output      rfr_pkg::q_push_t q_push
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = 13;
    localparam int QW = rfr_pkg::QCNT_W + 1;
    localparam int XW = rfr_pkg::XW;
    localparam int YW = rfr_pkg::YW;
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);

    logic          accept;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] wm1;
    logic [YW-1:0] h_eff;
    logic [YW-1:0] hm1;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [CW-1:0] x_ext;
    logic [CW-1:0] idx_full;
    logic [AW-1:0] idx;
    logic          last_col;
    logic          last_row;
    logic          filt;
    logic          border;
    logic          fwd;
    rfr_pkg::pix_t pix_in;

    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_reg;
    logic [YW-1:0] row_next;

    logic          f1_valid_reg;
    rfr_pkg::pix_t f1_pix_reg;
    logic [XW-1:0] f1_x_reg;
    logic [YW-1:0] f1_y_reg;
    logic [AW-1:0] f1_idx_reg;
    logic          f1_filt_reg;
    logic          f1_border_reg;
    logic          f1_fwd_reg;
    logic [31:0]   fwd_top_reg;
    logic [31:0]   fwd_mid_reg;

    logic [5:0][31:0] wc_reg;
    logic [5:0][31:0] wc_next;

    logic [63:0]   ls_rd;
    logic [31:0]   f1_top;
    logic [31:0]   f1_mid;
    logic [rfr_pkg::WIN_SIZE-1:0][31:0] w9;

    assign pix_ready = (QW'(q_stat.count) + QW'(f1_valid_reg)) < QW'(rfr_pkg::QUEUE_DEPTH);
    assign accept    = pix_valid && pix_ready;

    assign pix_in = '{alpha: pix_data.alpha_in, blue: pix_data.blue_in,
                      green: pix_data.green_in, red: pix_data.red_in};

    always_comb
    begin
        if (CW'(cfg.frame_width) < CW'(3))
        begin
            w_eff = CW'(3);
        end
        else if (CW'(cfg.frame_width) > MAXW_C)
        begin
            w_eff = MAXW_C;
        end
        else
        begin
            w_eff = CW'(cfg.frame_width);
        end
        wm1   = w_eff - CW'(1);
        h_eff = (cfg.frame_height < YW'(3)) ? YW'(3) : cfg.frame_height;
        hm1   = h_eff - YW'(1);

        x     = pix_data.frame_start ? '0 : col_reg;
        y     = pix_data.frame_start ? '0 : row_reg;
        x_ext = CW'(x);

        idx_full = (x_ext < MAXW_C) ? x_ext : (MAXW_C - CW'(1));
        idx      = idx_full[AW-1:0];

        last_col = x_ext >= wm1;
        last_row = y >= hm1;
        filt     = (x >= XW'(2)) && (x_ext <= wm1) && (y >= YW'(2)) && (y <= hm1);
        border   = (x == '0) || (y == '0) || last_col || last_row;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : (y + YW'(1));
        end
        else
        begin
            col_next = x + XW'(1);
            row_next = y;
        end

        // same line store entry as the word being written this cycle
        fwd = f1_valid_reg && (f1_idx_reg == idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
            wc_reg       <= '0;
        end
        else
        begin
            f1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (f1_valid_reg)
            begin
                wc_reg <= wc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_pix_reg    <= pix_in;
            f1_x_reg      <= x;
            f1_y_reg      <= y;
            f1_idx_reg    <= idx;
            f1_filt_reg   <= filt;
            f1_border_reg <= border;
            f1_fwd_reg    <= fwd;
            fwd_top_reg   <= f1_mid;
            fwd_mid_reg   <= f1_pix_reg;
        end
    end

    rfr_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (f1_valid_reg),
        .wr_addr (f1_idx_reg),
        .wr_data ({f1_mid, f1_pix_reg}),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (ls_rd)
    );

    // upper word: row y-2, lower word: row y-1
    assign f1_top = f1_fwd_reg ? fwd_top_reg : ls_rd[63:32];
    assign f1_mid = f1_fwd_reg ? fwd_mid_reg : ls_rd[31:0];

    always_comb
    begin
        wc_next[0] = wc_reg[3];
        wc_next[1] = wc_reg[4];
        wc_next[2] = wc_reg[5];
        wc_next[3] = f1_top;
        wc_next[4] = f1_mid;
        wc_next[5] = f1_pix_reg;

        w9[0] = wc_reg[0];
        w9[1] = wc_reg[3];
        w9[2] = f1_top;
        w9[3] = wc_reg[1];
        w9[4] = wc_reg[4];
        w9[5] = f1_mid;
        w9[6] = wc_reg[2];
        w9[7] = wc_reg[5];
        w9[8] = f1_pix_reg;

        q_push.valid = f1_valid_reg && (f1_filt_reg || f1_border_reg);
        for (int c = 0; c < rfr_pkg::NUM_CH; c++)
        begin
            for (int i = 0; i < rfr_pkg::WIN_SIZE; i++)
            begin
                q_push.entry.win[c][i] = w9[i][8*c +: 8];
            end
        end
        q_push.entry.center_alpha = wc_reg[4][31:24];
        q_push.entry.pix          = f1_pix_reg;
        q_push.entry.x            = f1_x_reg;
        q_push.entry.y            = f1_y_reg;
        q_push.entry.do_filt      = f1_filt_reg;
        q_push.entry.do_border    = f1_border_reg;
    end

endmodule

`default_nettype wire

### rtl/rfr_queue.sv
// Short FIFO of classified windows between the front end and the back end.
// Uses rfr_pkg.
`default_nettype none

module rfr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rfr_pkg::q_push_t  q_push,
    input  wire logic              q_pop,
    output      rfr_pkg::q_entry_t q_head,
    output      rfr_pkg::q_stat_t  q_stat
);

    localparam int DEPTH = rfr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = rfr_pkg::QCNT_W;

    rfr_pkg::q_entry_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : (wr_ptr_reg + PW'(1));
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : (rd_ptr_reg + PW'(1));
            end
            if (q_push.valid && !q_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (!q_push.valid && q_pop)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    assign q_head       = mem_reg[rd_ptr_reg];
    assign q_stat.valid = count_reg != '0;
    assign q_stat.count = count_reg;

endmodule

`default_nettype wire

### rtl/rfr_back.sv
// Back end: rank selection per channel over two stages, then result output
// register that emits the filtered word and the border word. Uses rfr_pkg.
`default_nettype none

module rfr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rfr_pkg::cfg_t     cfg,
    input  wire rfr_pkg::q_stat_t  q_stat,
    input  wire rfr_pkg::q_entry_t q_head,
    output      logic              q_pop,
    output      logic              res_valid,
    input  wire logic              res_ready,
    output      rfr_pkg::res_t     res_data
);

    localparam int NC = rfr_pkg::NUM_CH;
    localparam int WS = rfr_pkg::WIN_SIZE;
    localparam int RW = rfr_pkg::RANK_W;

    typedef logic [NC-1:0][WS-1:0][WS-1:0] below_t;

    function automatic logic [RW-1:0] pop9(input logic [WS-1:0] m);
        logic [RW-1:0] n;
        n = '0;
        for (int k = 0; k < WS; k++)
        begin
            n = n + RW'(m[k]);
        end
        return n;
    endfunction

    below_t                  below;
    logic [NC-1:0][7:0]      sel;
    logic [RW-1:0]           rank;
    logic                    out_load;
    logic                    b2_done;
    logic                    b2_free;
    logic                    b1_free;
    rfr_pkg::res_t           res_next;

    logic                    b1_valid_reg;
    rfr_pkg::q_entry_t       b1_entry_reg;
    below_t                  b1_below_reg;

    logic                    b2_valid_reg;
    logic                    b2_need_f_reg;
    logic                    b2_need_b_reg;
    rfr_pkg::q_entry_t       b2_entry_reg;
    logic [NC-1:0][7:0]      b2_filt_reg;

    logic                    res_valid_reg;
    rfr_pkg::res_t           res_data_reg;

    // element i ranks above j when larger; on a tie the higher index ranks above
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            for (int i = 0; i < WS; i++)
            begin
                for (int j = 0; j < WS; j++)
                begin
                    below[c][i][j] = (j != i) &&
                        ((q_head.win[c][j] < q_head.win[c][i]) ||
                         ((q_head.win[c][j] == q_head.win[c][i]) && (j < i)));
                end
            end
        end
    end

    always_comb
    begin
        rank = cfg.filter_mode ? RW'(rfr_pkg::MAX_RANK) : RW'(rfr_pkg::MEDIAN_RANK);
        for (int c = 0; c < NC; c++)
        begin
            sel[c] = '0;
            for (int i = 0; i < WS; i++)
            begin
                if (pop9(b1_below_reg[c][i]) == rank)
                begin
                    sel[c] = sel[c] | b1_entry_reg.win[c][i];
                end
            end
        end
    end

    always_comb
    begin
        out_load = b2_valid_reg && (!res_valid_reg || res_ready);
        b2_done  = out_load && !(b2_need_f_reg && b2_need_b_reg);
        b2_free  = !b2_valid_reg || b2_done;
        b1_free  = !b1_valid_reg || b2_free;
        q_pop    = q_stat.valid && b1_free;

        if (b2_need_f_reg)
        begin
            res_next.pixel_x      = b2_entry_reg.x - rfr_pkg::XW'(1);
            res_next.pixel_y      = b2_entry_reg.y - rfr_pkg::YW'(1);
            res_next.red_out      = b2_filt_reg[0];
            res_next.green_out    = b2_filt_reg[1];
            res_next.blue_out     = b2_filt_reg[2];
            res_next.alpha_out    = b2_entry_reg.center_alpha;
            res_next.was_filtered = 1'b1;
            res_next.last_of_run  = !b2_need_b_reg;
        end
        else
        begin
            res_next.pixel_x      = b2_entry_reg.x;
            res_next.pixel_y      = b2_entry_reg.y;
            res_next.red_out      = b2_entry_reg.pix.red;
            res_next.green_out    = b2_entry_reg.pix.green;
            res_next.blue_out     = b2_entry_reg.pix.blue;
            res_next.alpha_out    = b2_entry_reg.pix.alpha;
            res_next.was_filtered = 1'b0;
            res_next.last_of_run  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b2_need_f_reg <= 1'b0;
            b2_need_b_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_free)
            begin
                b1_valid_reg <= q_stat.valid;
            end
            if (b2_free)
            begin
                b2_valid_reg  <= b1_valid_reg;
                b2_need_f_reg <= b1_entry_reg.do_filt;
                b2_need_b_reg <= b1_entry_reg.do_border;
            end
            else if (out_load)
            begin
                b2_need_f_reg <= 1'b0;
            end
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_entry_reg <= q_head;
            b1_below_reg <= below;
        end
        if (b2_free && b1_valid_reg)
        begin
            b2_entry_reg <= b1_entry_reg;
            b2_filt_reg  <= sel;
        end
        if (out_load)
        begin
            res_data_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

### rtl/rank_filter_3x3_rgb_top.sv
// 3x3 RGB rank filter (median or maximum), top level. Uses rfr_pkg and all rfr_ modules.
// Throughput: one pixel per cycle while res_ready is high and each pixel causes at most one
// result word; pixels with two words (last row or column) hold the back end for both. Path:
// front end, queue, two rank stages, output register; a pair's second word follows once the
// first is taken. Rate limits: single line store RAM port pair, one result per cycle out.
// Reset: counters to (0,0), window cleared, config to defaults; line store is not cleared.
`default_nettype none

`include "rank_filter_3x3_rgb_top_macros.svh"

module rank_filter_3x3_rgb_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               pix_valid,
    output      logic                               pix_ready,
    input  wire rfr_pkg::pix_in_t                   pix_data,
    output      logic                               res_valid,
    input  wire logic                               res_ready,
    output      rfr_pkg::res_t                      res_data,
    input  wire logic                               cfg_we,
    input  wire logic [rfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rfr_pkg::cfg_t     cfg_reg;
    rfr_pkg::q_push_t  q_push;
    rfr_pkg::q_stat_t  q_stat;
    rfr_pkg::q_entry_t q_head;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= rfr_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= rfr_pkg::FRAME_HEIGHT_RST;
            cfg_reg.filter_mode  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfr_pkg::CFG_FRAME_WIDTH:
                begin
                    cfg_reg.frame_width <= cfg_data[rfr_pkg::FW_W-1:0];
                end
                rfr_pkg::CFG_FRAME_HEIGHT:
                begin
                    cfg_reg.frame_height <= cfg_data[rfr_pkg::YW-1:0];
                end
                rfr_pkg::CFG_FILTER_MODE:
                begin
                    cfg_reg.filter_mode <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    rfr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .q_stat    (q_stat),
        .q_push    (q_push)
    );

    rfr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    rfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    `RFR_ASSERT_IMP(a_queue_no_overflow, q_push.valid && !q_pop,
        q_stat.count != rfr_pkg::QUEUE_DEPTH, "queue overflow")
    `RFR_ASSERT_IMP(a_queue_no_underflow, q_pop, q_stat.count != 0, "queue underflow")
    `RFR_ASSERT_NXT(a_pair_follows, res_valid && res_ready && !res_data.last_of_run,
        res_valid && !res_data.was_filtered && res_data.last_of_run,
        "second word of a pair missing")
    `RFR_ASSERT_IMP(a_filtered_interior, res_valid && res_data.was_filtered,
        res_data.pixel_x != 0 && res_data.pixel_y != 0, "filtered word on border")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for rank_filter_3x3_rgb_top: a directed table, then random frames.
// Depends on rfr_pkg and the filter RTL; result words are checked against a fixed word for
// typed rows, else an in-bench model of line stores, 3x3 window and median / max selection.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX    = 1024;
    localparam int RAND_ITEMS  = 380;
    localparam int LAT_PAD     = 8;
    localparam int END_PAD     = 20;
    localparam int DRAIN_LIMIT = 4000;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;
    typedef enum int {CH_RED, CH_GREEN, CH_BLUE} chan_e;

    typedef struct packed {
        row_kind_e                      kind;
        logic [rfr_pkg::CFG_DATA_W-1:0] cfg_w;
        logic [rfr_pkg::CFG_DATA_W-1:0] cfg_h;
        logic                           cfg_m;
        rfr_pkg::pix_in_t               word;
        logic                           typed;
        rfr_pkg::res_t                  want;
    } stim_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           pix_valid = 1'b0;
    logic                           pix_ready;
    rfr_pkg::pix_in_t               pix_data  = '0;
    logic                           res_valid;
    logic                           res_ready = 1'b0;
    rfr_pkg::res_t                  res_data;
    logic                           cfg_we    = 1'b0;
    logic [rfr_pkg::CFG_IDX_W-1:0]  cfg_index = rfr_pkg::CFG_FRAME_WIDTH;
    logic [rfr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    always #4 clk = ~clk;

    rank_filter_3x3_rgb_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // window model state
    rfr_pkg::pix_t            upper_row  [LINE_MAX] = '{default: '0};
    rfr_pkg::pix_t            middle_row [LINE_MAX] = '{default: '0};
    rfr_pkg::pix_t            win_cols   [6]        = '{default: '0};
    rfr_pkg::pix_t            nbhd       [9];
    logic [rfr_pkg::XW-1:0]   col_pos    = '0;
    logic [rfr_pkg::YW-1:0]   row_pos    = '0;
    logic [rfr_pkg::FW_W-1:0] width_reg  = rfr_pkg::FRAME_WIDTH_RST;
    logic [rfr_pkg::YW-1:0]   height_reg = rfr_pkg::FRAME_HEIGHT_RST;
    logic                     mode_reg   = 1'b0;
    rfr_pkg::res_t            px_results [2];
    int                       px_count;

    rfr_pkg::res_t pending_results [$];
    stim_row_t     row_info        [$];
    int            fail_count = 0;
    bit            tx_idle    = 1'b1;
    bit            rx_idle    = 1'b1;
    int            cur_width  = 640;
    bit            need_fs    = 1'b0;

    function automatic string res_text(rfr_pkg::res_t r);
        return $sformatf("x=%0d y=%0d rgba=%h %h %h %h filt=%b last=%b",
                         r.pixel_x, r.pixel_y, r.red_out, r.green_out, r.blue_out,
                         r.alpha_out, r.was_filtered, r.last_of_run);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic logic [7:0] rank_value(chan_e ch, int rank);
        logic [7:0] v [9];
        int         below;
        int         same;
        int         i;
        int         j;
        for (i = 0; i < 9; i++)
        begin
            case (ch)
                CH_RED:   v[i] = nbhd[i].red;
                CH_GREEN: v[i] = nbhd[i].green;
                default:  v[i] = nbhd[i].blue;
            endcase
        end
        for (i = 0; i < 9; i++)
        begin
            below = 0;
            same  = 0;
            for (j = 0; j < 9; j++)
            begin
                if (v[j] < v[i])
                    below++;
                else if (v[j] == v[i])
                    same++;
            end
            if (rank >= below && rank < below + same)
                return v[i];
        end
        return 8'h00;
    endfunction

    function automatic void step_window(rfr_pkg::pix_in_t w);
        int unsigned   fw;
        int unsigned   fh;
        int unsigned   x;
        int unsigned   y;
        int            rank;
        rfr_pkg::pix_t cur;
        rfr_pkg::pix_t top;
        rfr_pkg::pix_t mid;
        rfr_pkg::res_t r;
        fw = width_reg;
        if (fw < 3)
            fw = 3;
        if (fw > LINE_MAX)
            fw = LINE_MAX;
        fh = height_reg;
        if (fh < 3)
            fh = 3;
        if (w.frame_start)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        x   = col_pos;
        y   = row_pos;
        cur = {w.alpha_in, w.blue_in, w.green_in, w.red_in};
        top = upper_row[x];
        mid = middle_row[x];
        nbhd[0] = win_cols[0];
        nbhd[1] = win_cols[3];
        nbhd[2] = top;
        nbhd[3] = win_cols[1];
        nbhd[4] = win_cols[4];
        nbhd[5] = mid;
        nbhd[6] = win_cols[2];
        nbhd[7] = win_cols[5];
        nbhd[8] = cur;
        px_count = 0;
        if (x >= 2 && x <= fw - 1 && y >= 2 && y <= fh - 1)
        begin
            rank           = mode_reg ? rfr_pkg::MAX_RANK : rfr_pkg::MEDIAN_RANK;
            r.pixel_x      = rfr_pkg::XW'(x - 1);
            r.pixel_y      = rfr_pkg::YW'(y - 1);
            r.red_out      = rank_value(CH_RED, rank);
            r.green_out    = rank_value(CH_GREEN, rank);
            r.blue_out     = rank_value(CH_BLUE, rank);
            r.alpha_out    = nbhd[4].alpha;
            r.was_filtered = 1'b1;
            r.last_of_run  = 1'b0;
            px_results[px_count] = r;
            px_count++;
        end
        if (x == 0 || y == 0 || x >= fw - 1 || y >= fh - 1)
        begin
            r.pixel_x      = rfr_pkg::XW'(x);
            r.pixel_y      = rfr_pkg::YW'(y);
            r.red_out      = cur.red;
            r.green_out    = cur.green;
            r.blue_out     = cur.blue;
            r.alpha_out    = cur.alpha;
            r.was_filtered = 1'b0;
            r.last_of_run  = 1'b0;
            px_results[px_count] = r;
            px_count++;
        end
        if (px_count > 0)
            px_results[px_count - 1].last_of_run = 1'b1;
        win_cols[0]   = win_cols[3];
        win_cols[1]   = win_cols[4];
        win_cols[2]   = win_cols[5];
        win_cols[3]   = top;
        win_cols[4]   = mid;
        win_cols[5]   = cur;
        upper_row[x]  = mid;
        middle_row[x] = cur;
        if (x >= fw - 1)
        begin
            col_pos = '0;
            row_pos = (y >= fh - 1) ? '0 : rfr_pkg::YW'(y + 1);
        end
        else
            col_pos = rfr_pkg::XW'(x + 1);
    endfunction

    function automatic stim_row_t row_pix(logic fs, logic [31:0] rgba);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_PIXEL;
        row.word = {fs, rgba};
        return row;
    endfunction

    function automatic stim_row_t row_border(logic fs, logic [31:0] rgba, int x, int y);
        stim_row_t row;
        row       = row_pix(fs, rgba);
        row.typed = 1'b1;
        row.want  = {rfr_pkg::XW'(x), rfr_pkg::YW'(y), rgba, 1'b0, 1'b1};
        return row;
    endfunction

    function automatic stim_row_t row_cfg(int w, int h, logic m);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_CONFIG;
        row.cfg_w = rfr_pkg::CFG_DATA_W'(w);
        row.cfg_h = rfr_pkg::CFG_DATA_W'(h);
        row.cfg_m = m;
        return row;
    endfunction

    always @(posedge clk)
    begin : monitor
        stim_row_t     row;
        rfr_pkg::res_t want;
        int            k;
        if (cfg_we)
        begin
            case (cfg_index)
                rfr_pkg::CFG_FRAME_WIDTH:  width_reg  = cfg_data[rfr_pkg::FW_W-1:0];
                rfr_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data[rfr_pkg::YW-1:0];
                rfr_pkg::CFG_FILTER_MODE:  mode_reg   = cfg_data[0];
                default: ;
            endcase
        end
        if (res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                note_failure({"unexpected word: ", res_text(res_data)});
            else
            begin
                want = pending_results.pop_front();
                if (res_data !== want)
                    note_failure({"mismatch: want ", res_text(want),
                                  ", got ", res_text(res_data)});
            end
        end
        if (pix_valid && pix_ready)
        begin
            row = row_info.pop_front();
            step_window(row.word);
            if (row.typed)
                pending_results.push_back(row.want);
            else
                for (k = 0; k < px_count; k++)
                    pending_results.push_back(px_results[k]);
        end
    end

    initial
    begin : receiver
        int stall;
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    task automatic send_row(stim_row_t row);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= row.word;
        row_info.push_back(row);
        do @(posedge clk); while (!pix_ready);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        pix_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
        if (pending_results.size() != 0)
        begin
            note_failure($sformatf("%0d words missing, oldest %s", pending_results.size(),
                                   res_text(pending_results[0])));
            pending_results.delete();
        end
        repeat (LAT_PAD) @(posedge clk);
    endtask

    task automatic set_config(int w, int h, logic m);
        int eff;
        drain_results();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rfr_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= rfr_pkg::CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= rfr_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= rfr_pkg::CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= rfr_pkg::CFG_FILTER_MODE;
        cfg_data  <= rfr_pkg::CFG_DATA_W'(m);
        @(posedge clk);
        cfg_we <= 1'b0;
        // a wider line reaches store entries never written: restart the frame
        eff = (w < 3) ? 3 : ((w > LINE_MAX) ? LINE_MAX : w);
        if (eff > cur_width)
            need_fs = 1'b1;
        cur_width = eff;
    endtask

    task automatic run_phase(int w, int h, logic m, int len);
        logic        fs;
        logic [31:0] rgba;
        int          k;
        set_config(w, h, m);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        for (k = 0; k < len; k++)
        begin
            fs      = need_fs || ($urandom_range(0, 39) == 0);
            need_fs = 1'b0;
            rgba    = $urandom;
            if ($urandom_range(0, 7) == 0)
                rgba = ($urandom & 32'h01010101) * 32'hff;
            send_row(row_pix(fs, rgba));
        end
    endtask

    initial
    begin : stimulus
        stim_row_t dir_table [$];
        int        w_raw;
        int        h_raw;
        int        len;
        int        rand_sent;
        dir_table = '{
            row_border(1'b0, 32'hffffffff, 0, 0),
            row_border(1'b0, 32'h00000000, 1, 0),
            row_cfg(3, 3, 1'b0),
            row_border(1'b0, 32'h12345678, 2, 0),
            row_pix(1'b1, 32'h10203040),
            row_pix(1'b0, 32'h80706050),
            row_pix(1'b0, 32'hff00ff00),
            row_pix(1'b0, 32'h00ff00ff),
            row_pix(1'b0, 32'h7f7f7f7f),
            row_pix(1'b0, 32'h01020304),
            row_pix(1'b0, 32'hfefefefe),
            row_pix(1'b0, 32'h80808080),
            row_pix(1'b0, 32'h55aa55aa),
            row_cfg(3, 3, 1'b1),
            row_pix(1'b1, 32'h00000000),
            row_pix(1'b0, 32'h000000ff),
            row_pix(1'b0, 32'h0000ff00),
            row_pix(1'b0, 32'h00ff0000),
            row_pix(1'b0, 32'hff000000),
            row_pix(1'b0, 32'h11111111),
            row_pix(1'b0, 32'h22222222),
            row_pix(1'b0, 32'h33333333),
            row_pix(1'b0, 32'h44444444),
            row_pix(1'b1, 32'hc0ffee00),
            row_pix(1'b0, 32'h0badf00d),
            row_pix(1'b1, 32'hdeadbeef)
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CONFIG)
                set_config(dir_table[i].cfg_w, dir_table[i].cfg_h, dir_table[i].cfg_m);
            else
                send_row(dir_table[i]);
        end

        // tallest frame, registers at zero, widest line
        run_phase(3, 4095, 1'b0, 70);
        run_phase(0, 0, 1'b1, 40);
        run_phase(2047, 3, 1'($urandom_range(0, 1)), LINE_MAX + 16);

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       w_raw = $urandom_range(0, 2);
                1:       w_raw = $urandom_range(13, 40);
                default: w_raw = $urandom_range(3, 12);
            endcase
            h_raw = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            len   = $urandom_range(10, 120);
            run_phase(w_raw, h_raw, 1'($urandom_range(0, 1)), len);
            rand_sent += len;
        end

        drain_results();
        repeat (END_PAD) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
